// ----- rtl/core/rvde_pkg.sv -----
// Shared types, opcodes and constants for the RV32I decode/execute unit.
// Used by the front end, the back end, the top level and the testbench.
`default_nettype none
package rvde_pkg;

  localparam int unsigned MemBytesDefault = 65536;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [6:0] OpcReg    = 7'h33;
  localparam logic [6:0] OpcImm    = 7'h13;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcJal    = 7'h6F;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcSystem = 7'h73;
  localparam logic [6:0] Funct7Alt = 7'h20;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusUnknown = 2'd1;
  localparam logic [1:0] StatusEcall   = 2'd2;

  localparam logic [4:0] RegA0 = 5'd10;
  localparam logic [4:0] RegA1 = 5'd11;
  localparam logic [4:0] RegA7 = 5'd17;

  typedef enum logic [3:0] {
    KindPreload,
    KindAlu,
    KindLoad,
    KindStore,
    KindBranch,
    KindLui,
    KindAuipc,
    KindJal,
    KindJalr,
    KindEcall,
    KindUnknown
  } kind_e;

  // Classified word handed from the front end to the back end.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] instr;
    logic [15:0] load_addr;
    logic [7:0]  load_byte;
    logic [31:0] imm;
  } decoded_t;

endpackage
`default_nettype wire

// ----- rtl/core/rv32i_decode_execute_unit.sv -----
// RV32I decode/execute unit: front end classifies words into a two-entry
// queue, back end executes them. Words other than loads and stores, and byte
// stores, finish in state StExec; wider stores go on through StMem, and loads
// through StMem and StDone, set by the single byte-wide data memory port.
// Throughput: one word per cycle for non-memory words when stall_i is low.
// Reset clears the register file, program counter and queue, not data memory.
`default_nettype none
module rv32i_decode_execute_unit #(
  parameter int unsigned MemBytes = rvde_pkg::MemBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic        op_i,
  input  wire logic [31:0] instr_i,
  input  wire logic [15:0] load_addr_i,
  input  wire logic [7:0]  load_byte_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      next_pc_o,
  output logic [1:0]       status_o,
  output logic             reg_written_o,
  output logic [4:0]       dest_index_o,
  output logic [31:0]      dest_value_o,
  output logic [31:0]      call_code_o,
  output logic [31:0]      call_arg0_o,
  output logic [31:0]      call_arg1_o
);

  logic q_valid, q_pop;
  rvde_pkg::decoded_t q_data;

  rvde_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .op_i, .instr_i, .load_addr_i, .load_byte_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  rvde_back #(.MemBytes(MemBytes)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .valid_o, .stall_i, .next_pc_o, .status_o, .reg_written_o, .dest_index_o,
    .dest_value_o, .call_code_o, .call_arg0_o, .call_arg1_o
  );

endmodule
`default_nettype wire

// ----- rtl/core/rvde_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rvde_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rvde_front.sv -----
// Front end: accepts words, classifies them, forms the immediate, and
// queues them for the back end. Depends on rvde_pkg.
`default_nettype none
module rvde_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic               op_i,
  input  wire logic [31:0]        instr_i,
  input  wire logic [15:0]        load_addr_i,
  input  wire logic [7:0]         load_byte_i,
  output logic                    q_valid_o,
  output rvde_pkg::decoded_t      q_data_o,
  input  wire logic               q_pop_i
);

  localparam int unsigned PtrW = $clog2(rvde_pkg::QueueDepth);

  rvde_pkg::decoded_t slot_q [rvde_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  rvde_pkg::decoded_t dec;
  logic push;
  logic [6:0] opc;
  logic [2:0] f3;
  logic [31:0] immi, imms, immb, immu, immj;

  assign opc = instr_i[6:0];
  assign f3  = instr_i[14:12];
  assign immi = {{21{instr_i[31]}}, instr_i[30:20]};
  assign imms = {{21{instr_i[31]}}, instr_i[30:25], instr_i[11:7]};
  assign immb = {{20{instr_i[31]}}, instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
  assign immu = {instr_i[31:12], 12'd0};
  assign immj = {{12{instr_i[31]}}, instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};

  always_comb begin
    dec.instr     = instr_i;
    dec.load_addr = load_addr_i;
    dec.load_byte = load_byte_i;
    dec.imm       = immi;
    dec.kind      = rvde_pkg::KindUnknown;
    if (op_i) begin
      dec.kind = rvde_pkg::KindPreload;
    end else begin
      case (opc)
        rvde_pkg::OpcReg: dec.kind = rvde_pkg::KindAlu;
        rvde_pkg::OpcImm: dec.kind = rvde_pkg::KindAlu;
        rvde_pkg::OpcLoad: begin
          if (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) dec.kind = rvde_pkg::KindLoad;
        end
        rvde_pkg::OpcStore: begin
          dec.imm = imms;
          if (f3 inside {3'd0, 3'd1, 3'd2}) dec.kind = rvde_pkg::KindStore;
        end
        rvde_pkg::OpcBranch: begin
          dec.imm = immb;
          if (!(f3 inside {3'd2, 3'd3})) dec.kind = rvde_pkg::KindBranch;
        end
        rvde_pkg::OpcLui: begin
          dec.imm = immu; dec.kind = rvde_pkg::KindLui;
        end
        rvde_pkg::OpcAuipc: begin
          dec.imm = immu; dec.kind = rvde_pkg::KindAuipc;
        end
        rvde_pkg::OpcJal: begin
          dec.imm = immj; dec.kind = rvde_pkg::KindJal;
        end
        rvde_pkg::OpcJalr: dec.kind = rvde_pkg::KindJalr;
        rvde_pkg::OpcSystem: dec.kind = rvde_pkg::KindEcall;
        default: dec.kind = rvde_pkg::KindUnknown;
      endcase
    end
  end

  assign stall_o   = (count_q == (PtrW+1)'(rvde_pkg::QueueDepth));
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (count_q != '0);
  assign q_data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (q_pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rvde_back.sv -----
// Back end: register file, program counter, ALU and byte-wide data memory
// sequencer. Depends on rvde_pkg and rvde_ram.
`default_nettype none
module rvde_back #(
  parameter int unsigned MemBytes = rvde_pkg::MemBytesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  rvde_pkg::decoded_t      q_data_i,
  output logic                    q_pop_o,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic [31:0]             next_pc_o,
  output logic [1:0]              status_o,
  output logic                    reg_written_o,
  output logic [4:0]              dest_index_o,
  output logic [31:0]             dest_value_o,
  output logic [31:0]             call_code_o,
  output logic [31:0]             call_arg0_o,
  output logic [31:0]             call_arg1_o
);

  localparam int unsigned AddrW = $clog2(MemBytes);

  typedef enum logic [1:0] {StExec, StMem, StDone} state_e;

  state_e state_q, state_d;
  logic [1:0] byte_q, byte_d;
  logic [31:0] regs_q [32];
  logic [31:0] pc_q;
  logic [31:0] acc_q, acc_d;
  logic [31:0] ea_q;
  logic [31:0] a, b, ea, alu_b, alu_val, last_byte_val;
  logic [1:0]  nbytes_m1;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic        alt, take;
  logic        out_full_q, out_free;
  logic        we, re, finish;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]  wdata, rdata;
  logic        has_rd;
  logic [31:0] val, npc;
  logic [1:0]  status;
  logic        is_last;

  rvde_pkg::decoded_t d;
  assign d  = q_data_i;
  assign rd = d.instr[11:7];
  assign f3 = d.instr[14:12];
  assign a  = (d.instr[19:15] == 5'd0) ? 32'd0 : regs_q[d.instr[19:15]];
  assign b  = (d.instr[24:20] == 5'd0) ? 32'd0 : regs_q[d.instr[24:20]];
  assign ea = a + d.imm;
  assign alt = (d.instr[31:25] == rvde_pkg::Funct7Alt);
  assign nbytes_m1 = (f3[1:0] == 2'd2) ? 2'd3 : ((f3[1:0] == 2'd1) ? 2'd1 : 2'd0);
  assign out_free = !out_full_q || !stall_i;

  always_comb begin
    alu_b = b;
    if (d.instr[6:0] == rvde_pkg::OpcImm) begin
      alu_b = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, d.instr[24:20]} : d.imm;
    end
    case (f3)
      3'd0: alu_val = (alt && d.instr[6:0] == rvde_pkg::OpcReg) ? a - alu_b : a + alu_b;
      3'd1: alu_val = a << alu_b[4:0];
      3'd2: alu_val = {31'd0, $signed(a) < $signed(alu_b)};
      3'd3: alu_val = {31'd0, a < alu_b};
      3'd4: alu_val = a ^ alu_b;
      3'd5: alu_val = (alt && (d.instr[6:0] == rvde_pkg::OpcReg || f3 == 3'd5))
                      ? 32'($signed(a) >>> alu_b[4:0]) : a >> alu_b[4:0];
      3'd6: alu_val = a | alu_b;
      default: alu_val = a & alu_b;
    endcase
    case (f3)
      3'd0, 3'd1: take = (a == b) ^ f3[0];
      3'd4, 3'd5: take = ($signed(a) < $signed(b)) ^ f3[0];
      3'd6, 3'd7: take = (a < b) ^ f3[0];
      default: take = 1'b0;
    endcase
  end

  // Assemble the loaded word; the byte from the RAM lands at the current lane.
  always_comb begin
    last_byte_val = acc_q;
    case (byte_q)
      2'd0: last_byte_val[7:0]   = rdata;
      2'd1: last_byte_val[15:8]  = rdata;
      2'd2: last_byte_val[23:16] = rdata;
      default: last_byte_val[31:24] = rdata;
    endcase
    if (f3 == 3'd0) last_byte_val = {{24{last_byte_val[7]}}, last_byte_val[7:0]};
    if (f3 == 3'd1) last_byte_val = {{16{last_byte_val[15]}}, last_byte_val[15:0]};
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    byte_d  = byte_q;
    acc_d   = acc_q;
    is_last = (byte_q == nbytes_m1);
    case (state_q)
      StExec: begin
        if (q_valid_i && out_free) begin
          if (d.kind == rvde_pkg::KindLoad) begin
            state_d = StMem; byte_d = 2'd0; acc_d = '0;
          end else if (d.kind == rvde_pkg::KindStore && nbytes_m1 != 2'd0) begin
            state_d = StMem; byte_d = 2'd1;
          end
        end
      end
      StMem: begin
        if (d.kind == rvde_pkg::KindLoad) begin
          acc_d = last_byte_val;
          if (is_last) begin
            state_d = StDone;
          end else begin
            byte_d = byte_q + 2'd1;
          end
        end else begin
          byte_d = byte_q + 2'd1;
          if (is_last) state_d = StExec;
        end
      end
      StDone: if (out_free) state_d = StExec;
      default: state_d = StExec;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    we = 1'b0; re = 1'b0; finish = 1'b0;
    waddr = ea[AddrW-1:0]; raddr = ea[AddrW-1:0];
    wdata = b[7:0];
    has_rd = 1'b0; val = alu_val; npc = pc_q + 32'd4; status = rvde_pkg::StatusOk;
    case (state_q)
      StExec: begin
        if (q_valid_i && out_free) begin
          case (d.kind)
            rvde_pkg::KindPreload: begin
              we = 1'b1; waddr = AddrW'(d.load_addr); wdata = d.load_byte;
              npc = pc_q; finish = 1'b1;
            end
            rvde_pkg::KindAlu: begin has_rd = 1'b1; finish = 1'b1; end
            rvde_pkg::KindLoad: re = 1'b1;
            rvde_pkg::KindStore: begin
              we = 1'b1; finish = (nbytes_m1 == 2'd0);
            end
            rvde_pkg::KindBranch: begin
              if (take) npc = pc_q + d.imm;
              finish = 1'b1;
            end
            rvde_pkg::KindLui: begin val = d.imm; has_rd = 1'b1; finish = 1'b1; end
            rvde_pkg::KindAuipc: begin val = pc_q + d.imm; has_rd = 1'b1; finish = 1'b1; end
            rvde_pkg::KindJal: begin
              val = pc_q + 32'd4; npc = pc_q + d.imm; has_rd = 1'b1; finish = 1'b1;
            end
            rvde_pkg::KindJalr: begin
              val = pc_q + 32'd4; npc = {ea[31:1], 1'b0}; has_rd = 1'b1; finish = 1'b1;
            end
            rvde_pkg::KindEcall: begin status = rvde_pkg::StatusEcall; finish = 1'b1; end
            default: begin status = rvde_pkg::StatusUnknown; finish = 1'b1; end
          endcase
        end
      end
      StMem: begin
        if (d.kind == rvde_pkg::KindLoad) begin
          raddr = AddrW'(ea_q + 32'(byte_q) + 32'd1);
          re = !is_last;
        end else begin
          we = 1'b1;
          waddr = AddrW'(ea_q + 32'(byte_q));
          case (byte_q)
            2'd1: wdata = b[15:8];
            2'd2: wdata = b[23:16];
            default: wdata = b[31:24];
          endcase
          finish = is_last;
        end
      end
      StDone: begin
        if (out_free) begin
          val = acc_q; has_rd = 1'b1; finish = 1'b1;
        end
      end
      default: finish = 1'b0;
    endcase
  end

  assign q_pop_o = finish;

  rvde_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == StExec) ea_q <= ea;
    if (finish) begin
      next_pc_o     <= npc;
      status_o      <= status;
      reg_written_o <= has_rd && (rd != 5'd0);
      dest_index_o  <= (has_rd && rd != 5'd0) ? rd : 5'd0;
      dest_value_o  <= (has_rd && rd != 5'd0) ? val : 32'd0;
      call_code_o   <= (status == rvde_pkg::StatusEcall) ? regs_q[rvde_pkg::RegA7] : 32'd0;
      call_arg0_o   <= (status == rvde_pkg::StatusEcall) ? regs_q[rvde_pkg::RegA0] : 32'd0;
      call_arg1_o   <= (status == rvde_pkg::StatusEcall) ? regs_q[rvde_pkg::RegA1] : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StExec;
      byte_q     <= '0;
      acc_q      <= '0;
      pc_q       <= '0;
      out_full_q <= 1'b0;
      for (int i = 0; i < 32; i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      byte_q  <= byte_d;
      acc_q   <= acc_d;
      if (finish) begin
        pc_q <= npc;
        if (has_rd && rd != 5'd0) regs_q[rd] <= val;
      end
      if (finish) out_full_q <= 1'b1;
      else if (!stall_i) out_full_q <= 1'b0;
    end
  end

  assign valid_o = out_full_q;

endmodule
`default_nettype wire

// ----- sim/rv32i_decode_execute_unit_tb.sv -----
// Self-checking testbench for rv32i_decode_execute_unit.
// Depends on rvde_pkg and the unit RTL. Keeps its own copy of the register file,
// PC and data memory, predicts every result word and checks it at the output.
`timescale 1ns / 1ps
module rv32i_decode_execute_unit_tb;

  localparam int unsigned NumRandom  = 900;
  localparam int unsigned CycleLimit = 400000;

  localparam logic [2:0] F3Byte  = 3'd0;
  localparam logic [2:0] F3Half  = 3'd1;
  localparam logic [2:0] F3Word  = 3'd2;
  localparam logic [2:0] F3ByteU = 3'd4;
  localparam logic [2:0] F3HalfU = 3'd5;

  localparam logic [2:0] AluAdd  = 3'd0;
  localparam logic [2:0] AluSll  = 3'd1;
  localparam logic [2:0] AluSlt  = 3'd2;
  localparam logic [2:0] AluSltu = 3'd3;
  localparam logic [2:0] AluXor  = 3'd4;
  localparam logic [2:0] AluSr   = 3'd5;
  localparam logic [2:0] AluOr   = 3'd6;

  localparam logic [2:0] BrEq  = 3'd0;
  localparam logic [2:0] BrNe  = 3'd1;
  localparam logic [2:0] BrLt  = 3'd4;
  localparam logic [2:0] BrGe  = 3'd5;
  localparam logic [2:0] BrLtu = 3'd6;
  localparam logic [2:0] BrGeu = 3'd7;

  typedef struct {
    logic [31:0] next_pc;
    logic [1:0]  status;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] call_code;
    logic [31:0] call_arg0;
    logic [31:0] call_arg1;
  } retire_t;

  typedef struct {
    logic        op;
    logic [31:0] instr;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        typed;
    logic [31:0] npc;
    logic [1:0]  status;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        op_i = 1'b0;
  logic [31:0] instr_i = '0;
  logic [15:0] load_addr_i = '0;
  logic [7:0]  load_byte_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] next_pc_o;
  logic [1:0]  status_o;
  logic        reg_written_o;
  logic [4:0]  dest_index_o;
  logic [31:0] dest_value_o;
  logic [31:0] call_code_o;
  logic [31:0] call_arg0_o;
  logic [31:0] call_arg1_o;

  rv32i_decode_execute_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow architectural state
  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic [7:0]  dmem [65536];
  bit          dmem_set [65536];

  retire_t retire_q [$];
  int unsigned errors = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  function automatic logic [31:0] rd_gpr(logic [4:0] i);
    return (i == 5'd0) ? 32'd0 : gpr[i];
  endfunction

  function automatic logic [31:0] alu_op(logic [2:0] f3, bit alt, logic [31:0] a,
                                         logic [31:0] b);
    case (f3)
      AluAdd:  return alt ? a - b : a + b;
      AluSll:  return a << b[4:0];
      AluSlt:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      AluSltu: return (a < b) ? 32'd1 : 32'd0;
      AluXor:  return a ^ b;
      AluSr:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      AluOr:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] read_bytes(logic [31:0] ea, int n);
    logic [31:0] v;
    logic [15:0] ix;
    v = '0;
    for (int i = 0; i < n; i++) begin
      ix = 16'(ea + i);
      v[8*i +: 8] = dmem[ix];
    end
    return v;
  endfunction

  // Execute one word on the shadow state and return its retire word.
  function automatic retire_t execute_word(logic op, logic [31:0] w, logic [15:0] addr,
                                           logic [7:0] data);
    retire_t r;
    logic [31:0] a, b, immi, imms, immb, immu, immj, v, ea;
    logic [4:0]  rd;
    logic [2:0]  f3;
    bit has_rd, take, alt;
    r = '{default: '0};
    r.next_pc = pc_q + 32'd4;
    has_rd = 1'b0;
    v = '0;
    if (op) begin
      dmem[addr] = data;
      dmem_set[addr] = 1'b1;
      r.next_pc = pc_q;
    end else begin
      rd = w[11:7];
      f3 = w[14:12];
      a = rd_gpr(w[19:15]);
      b = rd_gpr(w[24:20]);
      alt = (w[31:25] == rvde_pkg::Funct7Alt);
      immi = {{21{w[31]}}, w[30:20]};
      imms = {{21{w[31]}}, w[30:25], w[11:7]};
      immb = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      immu = {w[31:12], 12'd0};
      immj = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      case (w[6:0])
        rvde_pkg::OpcReg: begin
          v = alu_op(f3, alt, a, b);
          has_rd = 1'b1;
        end
        rvde_pkg::OpcImm: begin
          if (f3 == AluSll || f3 == AluSr) v = alu_op(f3, alt, a, {27'd0, w[24:20]});
          else v = alu_op(f3, 1'b0, a, immi);
          has_rd = 1'b1;
        end
        rvde_pkg::OpcLoad: begin
          ea = a + immi;
          has_rd = 1'b1;
          case (f3)
            F3Byte: begin
              v = read_bytes(ea, 1);
              v = {{24{v[7]}}, v[7:0]};
            end
            F3Half: begin
              v = read_bytes(ea, 2);
              v = {{16{v[15]}}, v[15:0]};
            end
            F3Word:  v = read_bytes(ea, 4);
            F3ByteU: v = read_bytes(ea, 1);
            F3HalfU: v = read_bytes(ea, 2);
            default: begin
              has_rd = 1'b0;
              r.status = rvde_pkg::StatusUnknown;
            end
          endcase
        end
        rvde_pkg::OpcStore: begin
          ea = a + imms;
          if (f3 <= F3Word) begin
            for (int i = 0; i < (1 << f3); i++) begin
              dmem[16'(ea + i)] = b[8*i +: 8];
              dmem_set[16'(ea + i)] = 1'b1;
            end
          end else begin
            r.status = rvde_pkg::StatusUnknown;
          end
        end
        rvde_pkg::OpcBranch: begin
          take = 1'b0;
          case (f3)
            BrEq:    take = (a == b);
            BrNe:    take = (a != b);
            BrLt:    take = ($signed(a) < $signed(b));
            BrGe:    take = ($signed(a) >= $signed(b));
            BrLtu:   take = (a < b);
            BrGeu:   take = (a >= b);
            default: r.status = rvde_pkg::StatusUnknown;
          endcase
          if (take) r.next_pc = pc_q + immb;
        end
        rvde_pkg::OpcLui: begin
          v = immu;
          has_rd = 1'b1;
        end
        rvde_pkg::OpcAuipc: begin
          v = pc_q + immu;
          has_rd = 1'b1;
        end
        rvde_pkg::OpcJal: begin
          v = pc_q + 32'd4;
          r.next_pc = pc_q + immj;
          has_rd = 1'b1;
        end
        rvde_pkg::OpcJalr: begin
          r.next_pc = (a + immi) & 32'hFFFF_FFFE;
          v = pc_q + 32'd4;
          has_rd = 1'b1;
        end
        rvde_pkg::OpcSystem: begin
          r.status = rvde_pkg::StatusEcall;
          r.call_code = gpr[rvde_pkg::RegA7];
          r.call_arg0 = gpr[rvde_pkg::RegA0];
          r.call_arg1 = gpr[rvde_pkg::RegA1];
        end
        default: r.status = rvde_pkg::StatusUnknown;
      endcase
      if (has_rd && rd != 5'd0) begin
        gpr[rd] = v;
        r.reg_written = 1'b1;
        r.dest_index = rd;
        r.dest_value = v;
      end
    end
    pc_q = r.next_pc;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one word and hold it until accepted.
  task automatic offer(logic op, logic [31:0] w, logic [15:0] addr, logic [7:0] data,
                       output retire_t r);
    int gap;
    r = execute_word(op, w, addr, data);
    retire_q.push_back(r);
    op_i        <= op;
    instr_i     <= w;
    load_addr_i <= addr;
    load_byte_i <= data;
    valid_i     <= 1'b1;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Preload any byte a load would read that was never written, then offer the word.
  task automatic issue_instr(logic [31:0] w);
    retire_t r;
    logic [31:0] ea;
    int n;
    if (w[6:0] == rvde_pkg::OpcLoad) begin
      ea = rd_gpr(w[19:15]) + {{21{w[31]}}, w[30:20]};
      n = (w[13:12] == 2'd2) ? 4 : (w[12] ? 2 : 1);
      for (int i = 0; i < n; i++) begin
        if (!dmem_set[16'(ea + i)]) offer(1'b1, $urandom(), 16'(ea + i), 8'($urandom()), r);
      end
    end
    offer(1'b0, w, 16'($urandom()), 8'($urandom()), r);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int k;
    w = $urandom();
    k = $urandom_range(0, 99);
    if (k < 18)      w[6:0] = rvde_pkg::OpcReg;
    else if (k < 36) w[6:0] = rvde_pkg::OpcImm;
    else if (k < 48) w[6:0] = rvde_pkg::OpcLoad;
    else if (k < 60) w[6:0] = rvde_pkg::OpcStore;
    else if (k < 72) w[6:0] = rvde_pkg::OpcBranch;
    else if (k < 77) w[6:0] = rvde_pkg::OpcLui;
    else if (k < 82) w[6:0] = rvde_pkg::OpcAuipc;
    else if (k < 87) w[6:0] = rvde_pkg::OpcJal;
    else if (k < 92) w[6:0] = rvde_pkg::OpcJalr;
    else if (k < 95) w[6:0] = rvde_pkg::OpcSystem;
    if ((w[6:0] == rvde_pkg::OpcReg || w[6:0] == rvde_pkg::OpcImm) && $urandom_range(0, 1))
      w[31:25] = rvde_pkg::Funct7Alt;
    // Keep about half of memory accesses near address zero so stores and loads overlap.
    if ((w[6:0] == rvde_pkg::OpcLoad || w[6:0] == rvde_pkg::OpcStore) && $urandom_range(0, 1))
      w[19:15] = 5'd0;
    return w;
  endfunction

  row_t rows [] = '{
    '{1'b0, 32'hFFF00093, '0, '0, 1'b1, 32'd4,  rvde_pkg::StatusOk},  // addi x1,x0,-1
    '{1'b0, 32'h7FF00113, '0, '0, 1'b1, 32'd8,  rvde_pkg::StatusOk},  // addi x2,x0,2047
    '{1'b0, 32'h800001B7, '0, '0, 1'b1, 32'd12, rvde_pkg::StatusOk},  // lui x3,0x80000
    '{1'b0, 32'h00208233, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // add
    '{1'b0, 32'h401182B3, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // sub
    '{1'b0, 32'h4021D333, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // sra by 31
    '{1'b0, 32'h4041D393, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // srai
    '{1'b0, 32'h0011A433, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // slt
    '{1'b0, 32'h0011B4B3, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // sltu
    '{1'b0, 32'h0020C533, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // xor
    '{1'b0, 32'h0020E5B3, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // or
    '{1'b0, 32'h0020F633, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // and
    '{1'b0, 32'h002096B3, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // sll
    '{1'b0, 32'h0020D733, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // srl
    '{1'b1, '0, 16'hFFFF, 8'hAA, 1'b1, 32'd56, rvde_pkg::StatusOk},   // preload keeps pc
    '{1'b0, 32'hFE102F23, '0, '0, 1'b1, 32'd60, rvde_pkg::StatusOk},  // sw wraps to 0
    '{1'b0, 32'hFFE02883, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // lw across wrap
    '{1'b0, 32'hFFF01903, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // lh
    '{1'b0, 32'hFFF04983, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // lbu
    '{1'b0, 32'hFFE05A03, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // lhu
    '{1'b0, 32'hFFF00A83, '0, '0, 1'b0, '0, rvde_pkg::StatusOk},      // lb
    '{1'b0, 32'h00003003, '0, '0, 1'b1, 32'd84, rvde_pkg::StatusUnknown},
    '{1'b0, 32'h00003023, '0, '0, 1'b1, 32'd88, rvde_pkg::StatusUnknown},
    '{1'b0, 32'h00002063, '0, '0, 1'b1, 32'd92, rvde_pkg::StatusUnknown},
    '{1'b0, 32'h0000007F, '0, '0, 1'b1, 32'd96, rvde_pkg::StatusUnknown},
    '{1'b0, 32'h00000073, '0, '0, 1'b1, 32'd100, rvde_pkg::StatusEcall},
    '{1'b0, 32'h0080006F, '0, '0, 1'b1, 32'd108, rvde_pkg::StatusOk}, // jal x0,+8
    '{1'b0, 32'h000080E7, '0, '0, 1'b0, '0, rvde_pkg::StatusOk}       // jalr x1,0(x1)
  };

  initial begin
    retire_t r;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    pc_q = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      offer(rows[i].op, rows[i].instr, rows[i].addr, rows[i].data, r);
      if (rows[i].typed && (r.next_pc !== rows[i].npc || r.status !== rows[i].status)) begin
        $display("%0t directed row %0d: expected pc %h status %0d, predicted %h %0d",
                 $time, i, rows[i].npc, rows[i].status, r.next_pc, r.status);
        errors++;
      end
    end

    for (int n = 0; n < NumRandom; n++) begin
      // Back up the output and keep pushing so the input stalls.
      if (n == 300) hold_req = 1'b1;
      if (n == 600) begin
        valid_i <= 1'b0;
        while (retire_q.size() != 0) @(posedge clk_i);
      end
      calm = (n >= 300 && n < 330) || (n >= 800 && n < 900);
      if ($urandom_range(0, 9) == 0) offer(1'b1, $urandom(), 16'($urandom()), 8'($urandom()), r);
      else issue_instr(random_word());
    end

    valid_i <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("** rv32i_decode_execute_unit: PASSED **");
    else $display("** rv32i_decode_execute_unit: FAILED **");
    $finish;
  end

  // Result side: random stall, one long hold, checking and the cycle limit.
  int unsigned cycles = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin
    retire_t e;
    int k;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** rv32i_decode_execute_unit: FAILED **");
      $finish;
    end else begin
      if (rst_ni && valid_o && !stall_i) begin
        if (retire_q.size() == 0) begin
          $display("%0t unexpected result word, pc %h", $time, next_pc_o);
          errors++;
        end else begin
          e = retire_q.pop_front();
          if (next_pc_o !== e.next_pc) begin
            $display("%0t next_pc: expected %h actual %h", $time, e.next_pc, next_pc_o);
            errors++;
          end
          if (status_o !== e.status) begin
            $display("%0t status: expected %0d actual %0d", $time, e.status, status_o);
            errors++;
          end
          if (reg_written_o !== e.reg_written) begin
            $display("%0t reg_written: expected %0d actual %0d", $time, e.reg_written,
                     reg_written_o);
            errors++;
          end
          if (dest_index_o !== e.dest_index) begin
            $display("%0t dest_index: expected %0d actual %0d", $time, e.dest_index,
                     dest_index_o);
            errors++;
          end
          if (dest_value_o !== e.dest_value) begin
            $display("%0t dest_value: expected %h actual %h", $time, e.dest_value,
                     dest_value_o);
            errors++;
          end
          if (call_code_o !== e.call_code) begin
            $display("%0t call_code: expected %h actual %h", $time, e.call_code, call_code_o);
            errors++;
          end
          if (call_arg0_o !== e.call_arg0) begin
            $display("%0t call_arg0: expected %h actual %h", $time, e.call_arg0, call_arg0_o);
            errors++;
          end
          if (call_arg1_o !== e.call_arg1) begin
            $display("%0t call_arg1: expected %h actual %h", $time, e.call_arg1, call_arg1_o);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall_i <= 1'b1;
      end else if (calm) begin
        stall_i <= 1'b0;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 80) stall_i <= 1'b0;
        else begin
          stall_i <= 1'b1;
          burst_left = (k < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

endmodule
